### design/cfdp_pkg.sv
// ----------------------------------------------------------------------------
// cfdp_pkg: shared types and constants of the complex fused dot product
// Widths, the item and result records and the register map used by the front,
// the queue and the back end.
// ----------------------------------------------------------------------------
package cfdp_pkg;

	// Column store
	localparam int NCOLS = 8;
	localparam int IDX_W = (NCOLS > 1) ? $clog2(NCOLS) : 1;
	localparam int COL_W = 3;

	// Queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = PTR_W + 1;

	// Datapath widths
	localparam int Y_W      = 16;             // Q1.15 sample
	localparam int OP_W     = Y_W + 1;        // operand after conjugation
	localparam int PROD_W   = 2 * OP_W;       // operand product
	localparam int PSUM_W   = PROD_W + 1;     // complex product part
	localparam int ACC_W    = 48;             // column accumulator
	localparam int ACC_LO_W = 16;             // low slice of accumulator split
	localparam int ACC_HI_W = ACC_W - ACC_LO_W;
	localparam int HPROD_W  = Y_W + ACC_HI_W;
	localparam int LPROD_W  = Y_W + ACC_LO_W + 1;
	localparam int HSUM_W   = HPROD_W + 1;
	localparam int LSUM_W   = LPROD_W + 1;
	localparam int SUM_W    = 67;             // exact finish sum
	localparam int FRAC_SH  = 30;             // Q.45 back to Q1.15
	localparam int BETA_SH  = 15;             // Q.30 up to Q.45
	localparam int Q_W      = SUM_W - FRAC_SH;

	localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) << (FRAC_SH - 1);
	localparam logic signed [Q_W-1:0]   Q_MAX = Q_W'(32767);
	localparam logic signed [Q_W-1:0]   Q_MIN = -(Q_W'(32768));
	localparam logic signed [Y_W-1:0]   Y_MAX = 16'sh7FFF;
	localparam logic signed [Y_W-1:0]   Y_MIN = 16'sh8000;
	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	// Stream widths
	localparam int S_TDATA_W = 104;
	localparam int M_TDATA_W = 40;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 16;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic {
		MODE_ACC = 1'b0,
		MODE_FIN = 1'b1
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CONJ_A   = 3'd0,
		REG_CONJ_X   = 3'd1,
		REG_ALPHA_RE = 3'd2,
		REG_ALPHA_IM = 3'd3,
		REG_BETA_RE  = 3'd4,
		REG_BETA_IM  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic                  conj_a;
		logic                  conj_x;
		logic signed [Y_W-1:0] alpha_re;
		logic signed [Y_W-1:0] alpha_im;
		logic signed [Y_W-1:0] beta_re;
		logic signed [Y_W-1:0] beta_im;
	} cfg_t;

	// Input transaction as it arrives on the stream
	typedef struct packed {
		mode_t                 mode;
		logic [COL_W-1:0]      col;
		logic signed [Y_W-1:0] a_re;
		logic signed [Y_W-1:0] a_im;
		logic signed [Y_W-1:0] x_re;
		logic signed [Y_W-1:0] x_im;
		logic signed [Y_W-1:0] y_re;
		logic signed [Y_W-1:0] y_im;
	} raw_t;

	// Classified item, conjugation already applied
	typedef struct packed {
		mode_t                  mode;
		idx_t                   col;
		logic signed [Y_W-1:0]  a_re;
		logic signed [OP_W-1:0] a_im;
		logic signed [Y_W-1:0]  x_re;
		logic signed [OP_W-1:0] x_im;
		logic signed [Y_W-1:0]  y_re;
		logic signed [Y_W-1:0]  y_im;
	} item_t;

	typedef struct packed {
		idx_t                  col;
		logic signed [Y_W-1:0] y_re;
		logic signed [Y_W-1:0] y_im;
		logic                  sat;
	} result_t;

endpackage

### design/cfdp_front.sv
// ----------------------------------------------------------------------------
// cfdp_front: input stage
// Takes stream transactions, drops items for columns outside the store,
// applies conjugation and hands the item to the queue.
// ----------------------------------------------------------------------------
module cfdp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  cfdp_pkg::cfg_t    cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  cfdp_pkg::raw_t    in_raw,
	input  logic              q_full,
	output logic              q_push,
	output cfdp_pkg::item_t   q_item
);

	logic            fr_valid_q;
	cfdp_pkg::item_t fr_item_q;
	cfdp_pkg::item_t item_d;
	logic            in_range;

	// Register frees when its item moves into the queue
	assign q_push   = fr_valid_q && !q_full;
	assign in_ready = !fr_valid_q || q_push;
	assign q_item   = fr_item_q;

	// Classify and conjugate
	always_comb begin
		in_range    = int'(in_raw.col) < cfdp_pkg::NCOLS;
		item_d.mode = in_raw.mode;
		item_d.col  = cfdp_pkg::idx_t'(in_raw.col);
		item_d.a_re = in_raw.a_re;
		item_d.x_re = in_raw.x_re;
		item_d.y_re = in_raw.y_re;
		item_d.y_im = in_raw.y_im;
		if (cfg.conj_a) begin
			item_d.a_im = -$signed({in_raw.a_im[cfdp_pkg::Y_W-1], in_raw.a_im});
		end else begin
			item_d.a_im = $signed({in_raw.a_im[cfdp_pkg::Y_W-1], in_raw.a_im});
		end
		if (cfg.conj_x) begin
			item_d.x_im = -$signed({in_raw.x_im[cfdp_pkg::Y_W-1], in_raw.x_im});
		end else begin
			item_d.x_im = $signed({in_raw.x_im[cfdp_pkg::Y_W-1], in_raw.x_im});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			fr_valid_q <= in_range;
		end else if (q_push) begin
			fr_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			fr_item_q <= item_d;
		end
	end

endmodule

### design/cfdp_fifo.sv
// ----------------------------------------------------------------------------
// cfdp_fifo: item queue
// Short first-in first-out buffer between the front stage and the back end.
// ----------------------------------------------------------------------------
module cfdp_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cfdp_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output cfdp_pkg::item_t head,
	output logic            empty
);

	cfdp_pkg::item_t mem_q [cfdp_pkg::FIFO_DEPTH];
	cfdp_pkg::ptr_t  wr_ptr_q;
	cfdp_pkg::ptr_t  rd_ptr_q;
	cfdp_pkg::cnt_t  count_q;

	assign full  = count_q == cfdp_pkg::CNT_W'(cfdp_pkg::FIFO_DEPTH);
	assign empty = count_q == '0;
	assign head  = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10: begin
					count_q <= count_q + 1'b1;
				end
				2'b01: begin
					count_q <= count_q - 1'b1;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

endmodule

### design/cfdp_back.sv
// ----------------------------------------------------------------------------
// cfdp_back: multiply-accumulate and finish pipeline
// Shared complex multiplier, column accumulators with saturation, and the
// alpha/beta scaling, rounding and output register of finish items.
// ----------------------------------------------------------------------------
module cfdp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  cfdp_pkg::cfg_t    cfg,
	input  logic              q_empty,
	input  cfdp_pkg::item_t   q_head,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output cfdp_pkg::result_t out_res
);

	localparam int PSUM_W  = cfdp_pkg::PSUM_W;
	localparam int PROD_W  = cfdp_pkg::PROD_W;
	localparam int OP_W    = cfdp_pkg::OP_W;
	localparam int ACC_W   = cfdp_pkg::ACC_W;
	localparam int SUM_W   = cfdp_pkg::SUM_W;

	logic adv;

	// Stage 1: operand products
	logic                     v_s1;
	cfdp_pkg::mode_t          mode_s1;
	cfdp_pkg::idx_t           col_s1;
	logic signed [PROD_W-1:0] p0_s1, p1_s1, p2_s1, p3_s1;
	logic signed [OP_W-1:0]   op_re1, op_im1, op_re2, op_im2;

	// Stage 2: complex product
	logic                     v_s2;
	cfdp_pkg::mode_t          mode_s2;
	cfdp_pkg::idx_t           col_s2;
	logic signed [PSUM_W-1:0] pr_s2, pi_s2;

	// Accumulators
	logic signed [ACC_W-1:0] acc_re_q [cfdp_pkg::NCOLS];
	logic signed [ACC_W-1:0] acc_im_q [cfdp_pkg::NCOLS];
	logic                    clip_q   [cfdp_pkg::NCOLS];
	logic signed [ACC_W-1:0] cur_re, cur_im, nxt_re, nxt_im;
	logic signed [ACC_W:0]   sum_re, sum_im;
	logic                    ovf_re, ovf_im;

	// Stage 3: captured column for a finish
	logic                     v_s3;
	cfdp_pkg::idx_t           col_s3;
	logic                     clip_s3;
	logic signed [ACC_W-1:0]  cr_s3, ci_s3;
	logic signed [PSUM_W-1:0] bre_s3, bim_s3;
	logic signed [cfdp_pkg::ACC_HI_W-1:0] crh, cih;
	logic signed [cfdp_pkg::ACC_LO_W:0]   crl, cil;

	// Stage 4: alpha partial products
	logic                     v_s4;
	cfdp_pkg::idx_t           col_s4;
	logic                     clip_s4;
	logic signed [PSUM_W-1:0] bre_s4, bim_s4;
	logic signed [cfdp_pkg::HPROD_W-1:0] rrh_s4, iih_s4, rih_s4, irh_s4;
	logic signed [cfdp_pkg::LPROD_W-1:0] rrl_s4, iil_s4, ril_s4, irl_s4;

	// Stage 5: partial sums
	logic                     v_s5;
	cfdp_pkg::idx_t           col_s5;
	logic                     clip_s5;
	logic signed [PSUM_W-1:0] bre_s5, bim_s5;
	logic signed [cfdp_pkg::HSUM_W-1:0] hre_s5, him_s5;
	logic signed [cfdp_pkg::LSUM_W-1:0] lre_s5, lim_s5;

	// Stage 6: exact sum with rounding bias
	logic                    v_s6;
	cfdp_pkg::idx_t          col_s6;
	logic                    clip_s6;
	logic signed [SUM_W-1:0] sum_re_s6, sum_im_s6;

	// Output register
	logic                         out_valid_q;
	cfdp_pkg::result_t            out_q;
	logic signed [cfdp_pkg::Q_W-1:0] q_re, q_im;
	logic signed [cfdp_pkg::Y_W-1:0] y_re, y_im;
	logic                         sat_re, sat_im;

	// Whole pipeline moves unless a result waits at the output
	assign adv       = !out_valid_q || out_ready;
	assign q_pop     = adv && !q_empty;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	// Operand select: accumulate uses a and x, finish uses beta and y_old
	always_comb begin
		if (q_head.mode == cfdp_pkg::MODE_FIN) begin
			op_re1 = OP_W'(cfg.beta_re);
			op_im1 = OP_W'(cfg.beta_im);
			op_re2 = OP_W'(q_head.y_re);
			op_im2 = OP_W'(q_head.y_im);
		end else begin
			op_re1 = OP_W'(q_head.a_re);
			op_im1 = q_head.a_im;
			op_re2 = OP_W'(q_head.x_re);
			op_im2 = q_head.x_im;
		end
	end

	// Accumulator update with 48-bit saturation
	always_comb begin
		cur_re = acc_re_q[col_s2];
		cur_im = acc_im_q[col_s2];
		sum_re = (ACC_W+1)'(cur_re) + (ACC_W+1)'(pr_s2);
		sum_im = (ACC_W+1)'(cur_im) + (ACC_W+1)'(pi_s2);
		ovf_re = sum_re[ACC_W] != sum_re[ACC_W-1];
		ovf_im = sum_im[ACC_W] != sum_im[ACC_W-1];
		if (ovf_re) begin
			nxt_re = sum_re[ACC_W] ? cfdp_pkg::ACC_MIN : cfdp_pkg::ACC_MAX;
		end else begin
			nxt_re = sum_re[ACC_W-1:0];
		end
		if (ovf_im) begin
			nxt_im = sum_im[ACC_W] ? cfdp_pkg::ACC_MIN : cfdp_pkg::ACC_MAX;
		end else begin
			nxt_im = sum_im[ACC_W-1:0];
		end
	end

	// Split accumulators so each multiply stays within 16x32
	always_comb begin
		crh = cr_s3[ACC_W-1:cfdp_pkg::ACC_LO_W];
		cih = ci_s3[ACC_W-1:cfdp_pkg::ACC_LO_W];
		crl = $signed({1'b0, cr_s3[cfdp_pkg::ACC_LO_W-1:0]});
		cil = $signed({1'b0, ci_s3[cfdp_pkg::ACC_LO_W-1:0]});
	end

	// Round by arithmetic shift, then clamp to Q1.15
	always_comb begin
		q_re = sum_re_s6[SUM_W-1:cfdp_pkg::FRAC_SH];
		q_im = sum_im_s6[SUM_W-1:cfdp_pkg::FRAC_SH];
		sat_re = (q_re > cfdp_pkg::Q_MAX) || (q_re < cfdp_pkg::Q_MIN);
		sat_im = (q_im > cfdp_pkg::Q_MAX) || (q_im < cfdp_pkg::Q_MIN);
		if (q_re > cfdp_pkg::Q_MAX) begin
			y_re = cfdp_pkg::Y_MAX;
		end else if (q_re < cfdp_pkg::Q_MIN) begin
			y_re = cfdp_pkg::Y_MIN;
		end else begin
			y_re = q_re[cfdp_pkg::Y_W-1:0];
		end
		if (q_im > cfdp_pkg::Q_MAX) begin
			y_im = cfdp_pkg::Y_MAX;
		end else if (q_im < cfdp_pkg::Q_MIN) begin
			y_im = cfdp_pkg::Y_MIN;
		end else begin
			y_im = q_im[cfdp_pkg::Y_W-1:0];
		end
	end

	// Valid bits and accumulator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < cfdp_pkg::NCOLS; i++) begin
				acc_re_q[i] <= '0;
				acc_im_q[i] <= '0;
				clip_q[i]   <= 1'b0;
			end
		end else if (adv) begin
			v_s1        <= q_pop;
			v_s2        <= v_s1;
			v_s3        <= v_s2 && (mode_s2 == cfdp_pkg::MODE_FIN);
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			out_valid_q <= v_s6;
			if (v_s2) begin
				if (mode_s2 == cfdp_pkg::MODE_ACC) begin
					acc_re_q[col_s2] <= nxt_re;
					acc_im_q[col_s2] <= nxt_im;
					clip_q[col_s2]   <= clip_q[col_s2] || ovf_re || ovf_im;
				end else begin
					acc_re_q[col_s2] <= '0;
					acc_im_q[col_s2] <= '0;
					clip_q[col_s2]   <= 1'b0;
				end
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (adv) begin
			// stage 1
			mode_s1 <= q_head.mode;
			col_s1  <= q_head.col;
			p0_s1   <= PROD_W'(op_re1) * PROD_W'(op_re2);
			p1_s1   <= PROD_W'(op_im1) * PROD_W'(op_im2);
			p2_s1   <= PROD_W'(op_re1) * PROD_W'(op_im2);
			p3_s1   <= PROD_W'(op_im1) * PROD_W'(op_re2);
			// stage 2
			mode_s2 <= mode_s1;
			col_s2  <= col_s1;
			pr_s2   <= PSUM_W'(p0_s1) - PSUM_W'(p1_s1);
			pi_s2   <= PSUM_W'(p2_s1) + PSUM_W'(p3_s1);
			// stage 3
			col_s3  <= col_s2;
			clip_s3 <= clip_q[col_s2];
			cr_s3   <= cur_re;
			ci_s3   <= cur_im;
			bre_s3  <= pr_s2;
			bim_s3  <= pi_s2;
			// stage 4
			col_s4  <= col_s3;
			clip_s4 <= clip_s3;
			bre_s4  <= bre_s3;
			bim_s4  <= bim_s3;
			rrh_s4  <= cfdp_pkg::HPROD_W'(cfg.alpha_re) * cfdp_pkg::HPROD_W'(crh);
			iih_s4  <= cfdp_pkg::HPROD_W'(cfg.alpha_im) * cfdp_pkg::HPROD_W'(cih);
			rih_s4  <= cfdp_pkg::HPROD_W'(cfg.alpha_re) * cfdp_pkg::HPROD_W'(cih);
			irh_s4  <= cfdp_pkg::HPROD_W'(cfg.alpha_im) * cfdp_pkg::HPROD_W'(crh);
			rrl_s4  <= cfdp_pkg::LPROD_W'(cfg.alpha_re) * cfdp_pkg::LPROD_W'(crl);
			iil_s4  <= cfdp_pkg::LPROD_W'(cfg.alpha_im) * cfdp_pkg::LPROD_W'(cil);
			ril_s4  <= cfdp_pkg::LPROD_W'(cfg.alpha_re) * cfdp_pkg::LPROD_W'(cil);
			irl_s4  <= cfdp_pkg::LPROD_W'(cfg.alpha_im) * cfdp_pkg::LPROD_W'(crl);
			// stage 5
			col_s5  <= col_s4;
			clip_s5 <= clip_s4;
			bre_s5  <= bre_s4;
			bim_s5  <= bim_s4;
			hre_s5  <= cfdp_pkg::HSUM_W'(rrh_s4) - cfdp_pkg::HSUM_W'(iih_s4);
			him_s5  <= cfdp_pkg::HSUM_W'(rih_s4) + cfdp_pkg::HSUM_W'(irh_s4);
			lre_s5  <= cfdp_pkg::LSUM_W'(rrl_s4) - cfdp_pkg::LSUM_W'(iil_s4);
			lim_s5  <= cfdp_pkg::LSUM_W'(ril_s4) + cfdp_pkg::LSUM_W'(irl_s4);
			// stage 6
			col_s6    <= col_s5;
			clip_s6   <= clip_s5;
			sum_re_s6 <= (SUM_W'(hre_s5) <<< cfdp_pkg::ACC_LO_W) + SUM_W'(lre_s5)
				+ (SUM_W'(bre_s5) <<< cfdp_pkg::BETA_SH) + cfdp_pkg::ROUND_BIAS;
			sum_im_s6 <= (SUM_W'(him_s5) <<< cfdp_pkg::ACC_LO_W) + SUM_W'(lim_s5)
				+ (SUM_W'(bim_s5) <<< cfdp_pkg::BETA_SH) + cfdp_pkg::ROUND_BIAS;
			// output
			out_q.col  <= col_s6;
			out_q.y_re <= y_re;
			out_q.y_im <= y_im;
			out_q.sat  <= clip_s6 || sat_re || sat_im;
		end
	end

	// A finish leaves its column empty and unclipped
	a_fin_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s2 && mode_s2 == cfdp_pkg::MODE_FIN) |=>
		(acc_re_q[$past(col_s2)] == '0 && acc_im_q[$past(col_s2)] == '0 &&
		!clip_q[$past(col_s2)]))
		else $error("accumulator not cleared by finish");

	// Clip flag stays set across accumulates
	a_clip_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s2 && mode_s2 == cfdp_pkg::MODE_ACC && clip_q[col_s2]) |=>
		clip_q[$past(col_s2)])
		else $error("accumulator clip flag lost");

	// A zero product leaves the accumulator unchanged
	a_zero_product: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s2 && mode_s2 == cfdp_pkg::MODE_ACC && pr_s2 == '0 && pi_s2 == '0) |=>
		(acc_re_q[$past(col_s2)] == $past(acc_re_q[col_s2]) &&
		acc_im_q[$past(col_s2)] == $past(acc_im_q[col_s2])))
		else $error("accumulator changed by zero product");

	// Stalled pipeline holds its finish stages
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(v_s3) && $stable(v_s6) && $stable(sum_re_s6)))
		else $error("pipeline moved during stall");

	// A result appears only from a finish in the last stage
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(v_s6 && adv))
		else $error("result without finish item");

endmodule

### design/complex_fused_dot_product_top.sv
// ----------------------------------------------------------------------------
// complex_fused_dot_product_top: complex dot product with scaled y update
// An accepted finish transaction passes the front register, the queue, stages
// s1 to s6 and the output register on its way to m_tvalid. Throughput: one
// transaction per cycle while m_tready does not hold the output.
// Reset clears the column accumulators, clip flags, queue and pipeline at
// once and loads alpha = 32767 + 0i, beta = 0, no conjugation.
// ----------------------------------------------------------------------------
module complex_fused_dot_product_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [cfdp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cfdp_pkg::CFG_W-1:0]        cfg_wdata,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// col, a_re, a_im, x_re, x_im, y_old_re, y_old_im, zero fill
	input  logic [cfdp_pkg::S_TDATA_W-1:0]    s_tdata,
	// mode
	input  logic                              s_tuser,
	// output stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// out_col, y_new_re, y_new_im, zero fill
	output logic [cfdp_pkg::M_TDATA_W-1:0]    m_tdata,
	// saturated
	output logic                              m_tuser
);

	logic                  conj_a_q, conj_x_q;
	logic signed [15:0]    alpha_re_q, alpha_im_q, beta_re_q, beta_im_q;
	cfdp_pkg::cfg_t        cfg;
	cfdp_pkg::raw_t        raw;
	cfdp_pkg::item_t       push_item, head;
	logic                  push, pop, full, empty;
	cfdp_pkg::result_t     res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conj_a_q   <= 1'b0;
			conj_x_q   <= 1'b0;
			alpha_re_q <= 16'sh7FFF;
			alpha_im_q <= '0;
			beta_re_q  <= '0;
			beta_im_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cfdp_pkg::REG_CONJ_A:   conj_a_q   <= cfg_wdata[0];
				cfdp_pkg::REG_CONJ_X:   conj_x_q   <= cfg_wdata[0];
				cfdp_pkg::REG_ALPHA_RE: alpha_re_q <= cfg_wdata;
				cfdp_pkg::REG_ALPHA_IM: alpha_im_q <= cfg_wdata;
				cfdp_pkg::REG_BETA_RE:  beta_re_q  <= cfg_wdata;
				cfdp_pkg::REG_BETA_IM:  beta_im_q  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign cfg.conj_a   = conj_a_q;
	assign cfg.conj_x   = conj_x_q;
	assign cfg.alpha_re = alpha_re_q;
	assign cfg.alpha_im = alpha_im_q;
	assign cfg.beta_re  = beta_re_q;
	assign cfg.beta_im  = beta_im_q;

	// Unpack input transaction
	assign raw.mode = cfdp_pkg::mode_t'(s_tuser);
	assign raw.col  = s_tdata[2:0];
	assign raw.a_re = s_tdata[18:3];
	assign raw.a_im = s_tdata[34:19];
	assign raw.x_re = s_tdata[50:35];
	assign raw.x_im = s_tdata[66:51];
	assign raw.y_re = s_tdata[82:67];
	assign raw.y_im = s_tdata[98:83];

	cfdp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_raw   (raw),
		.q_full   (full),
		.q_push   (push),
		.q_item   (push_item)
	);

	cfdp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	cfdp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_empty   (empty),
		.q_head    (head),
		.q_pop     (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	// Pack output transaction
	assign m_tdata = {5'b0, res.y_im, res.y_re, cfdp_pkg::COL_W'(res.col)};
	assign m_tuser = res.sat;

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the complex fused dot product
// Streams accumulate and finish transactions into the block. A behavioral
// copy of the column accumulators and the coefficients predicts every new y
// value, and each output transaction is checked field by field against it.
// A directed table runs first, including long accumulations whose scaled
// results clip. Random column runs follow under several coefficient settings
// and several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_top;

	// wide enough for the exact finish sum
	typedef logic signed [79:0] wide_t;

	typedef enum {ROW_CFG, ROW_ITEM} row_kind_t;

	typedef struct {
		row_kind_t                  kind;
		cfdp_pkg::reg_idx_t         idx;
		logic [cfdp_pkg::CFG_W-1:0] val;
		cfdp_pkg::raw_t             item;
		int                         reps;
		bit                         typed;
		cfdp_pkg::result_t          want;
	} plan_row_t;

	// shorthand for the directed table
	localparam logic [cfdp_pkg::Y_W-1:0] QMAX  = cfdp_pkg::Y_MAX;
	localparam logic [cfdp_pkg::Y_W-1:0] QMIN  = cfdp_pkg::Y_MIN;
	localparam cfdp_pkg::mode_t          M_ACC = cfdp_pkg::MODE_ACC;
	localparam cfdp_pkg::mode_t          M_FIN = cfdp_pkg::MODE_FIN;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           cfg_we    = 1'b0;
	logic [cfdp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [cfdp_pkg::CFG_W-1:0]     cfg_wdata = '0;
	logic                           s_tvalid  = 1'b0;
	logic                           s_tready;
	logic [cfdp_pkg::S_TDATA_W-1:0] s_tdata   = '0;
	logic                           s_tuser   = 1'b0;
	logic                           m_tvalid;
	logic                           m_tready  = 1'b0;
	logic [cfdp_pkg::M_TDATA_W-1:0] m_tdata;
	logic                           m_tuser;

	// predictor state
	longint            acc_re_q   [cfdp_pkg::NCOLS];
	longint            acc_im_q   [cfdp_pkg::NCOLS];
	bit                acc_clip_q [cfdp_pkg::NCOLS];
	cfdp_pkg::cfg_t    coef;
	cfdp_pkg::result_t pending_y  [$];
	plan_row_t         plan       [$];
	int                mismatches     = 0;
	int                send_idle_pct  = 0;
	int                recv_stall_pct = 0;

	complex_fused_dot_product_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Saturate an accumulator value to 48 bits
	function automatic longint sat_acc48(input longint v, inout bit clip);
		if (v > longint'(cfdp_pkg::ACC_MAX)) begin
			clip = 1'b1;
			return longint'(cfdp_pkg::ACC_MAX);
		end
		if (v < longint'(cfdp_pkg::ACC_MIN)) begin
			clip = 1'b1;
			return longint'(cfdp_pkg::ACC_MIN);
		end
		return v;
	endfunction

	// Q.45 sum to Q1.15: round half up, then clamp
	function automatic logic signed [cfdp_pkg::Y_W-1:0] round_q15(input wide_t s,
		inout bit clip);
		wide_t q;
		q = (s + (wide_t'(1) <<< (cfdp_pkg::FRAC_SH - 1))) >>> cfdp_pkg::FRAC_SH;
		if (q > wide_t'(cfdp_pkg::Y_MAX)) begin
			clip = 1'b1;
			return cfdp_pkg::Y_MAX;
		end
		if (q < wide_t'(cfdp_pkg::Y_MIN)) begin
			clip = 1'b1;
			return cfdp_pkg::Y_MIN;
		end
		return q[cfdp_pkg::Y_W-1:0];
	endfunction

	// Apply one transaction to the column state; returns 1 with a new y
	function automatic bit column_update(input cfdp_pkg::raw_t it,
		output cfdp_pkg::result_t res);
		int     c;
		longint ar, ai, xr, xi, pr, pi;
		longint yr, yi, cr, ci, b_re, b_im;
		wide_t  s_re, s_im;
		bit     clip;
		res = '0;
		if (int'(it.col) >= cfdp_pkg::NCOLS)
			return 1'b0;
		c    = int'(it.col);
		clip = acc_clip_q[c];
		if (it.mode == cfdp_pkg::MODE_ACC) begin
			ar = longint'(it.a_re);
			ai = longint'(it.a_im);
			xr = longint'(it.x_re);
			xi = longint'(it.x_im);
			if (coef.conj_a)
				ai = -ai;
			if (coef.conj_x)
				xi = -xi;
			pr = ar * xr - ai * xi;
			pi = ar * xi + ai * xr;
			acc_re_q[c]   = sat_acc48(acc_re_q[c] + pr, clip);
			acc_im_q[c]   = sat_acc48(acc_im_q[c] + pi, clip);
			acc_clip_q[c] = clip;
			return 1'b0;
		end
		// finish: beta*y lifted to Q.45, plus alpha*acc
		yr   = longint'(it.y_re);
		yi   = longint'(it.y_im);
		cr   = acc_re_q[c];
		ci   = acc_im_q[c];
		b_re = (longint'(coef.beta_re) * yr - longint'(coef.beta_im) * yi)
			<<< cfdp_pkg::BETA_SH;
		b_im = (longint'(coef.beta_re) * yi + longint'(coef.beta_im) * yr)
			<<< cfdp_pkg::BETA_SH;
		s_re = wide_t'(longint'(coef.alpha_re) * cr) - wide_t'(longint'(coef.alpha_im) * ci)
			+ wide_t'(b_re);
		s_im = wide_t'(longint'(coef.alpha_re) * ci) + wide_t'(longint'(coef.alpha_im) * cr)
			+ wide_t'(b_im);
		res.col  = cfdp_pkg::idx_t'(it.col);
		res.y_re = round_q15(s_re, clip);
		res.y_im = round_q15(s_im, clip);
		res.sat  = clip;
		acc_re_q[c]   = 0;
		acc_im_q[c]   = 0;
		acc_clip_q[c] = 1'b0;
		return 1'b1;
	endfunction

	// Random Q1.15 value, biased toward the extremes
	function automatic logic [cfdp_pkg::Y_W-1:0] rand_q15();
		case ($urandom_range(15))
			0, 1:    return cfdp_pkg::Y_MIN;
			2, 3:    return cfdp_pkg::Y_MAX;
			4:       return '0;
			default: return cfdp_pkg::Y_W'($urandom);
		endcase
	endfunction

	function automatic cfdp_pkg::raw_t rand_item(input cfdp_pkg::mode_t mode,
		input logic [cfdp_pkg::COL_W-1:0] col);
		cfdp_pkg::raw_t it;
		it.mode = mode;
		it.col  = col;
		it.a_re = rand_q15();
		it.a_im = rand_q15();
		it.x_re = rand_q15();
		it.x_im = rand_q15();
		it.y_re = rand_q15();
		it.y_im = rand_q15();
		return it;
	endfunction

	// Directed table builders
	function automatic void plan_cfg(input cfdp_pkg::reg_idx_t idx,
		input logic [cfdp_pkg::CFG_W-1:0] val);
		plan_row_t row;
		row.kind  = ROW_CFG;
		row.idx   = idx;
		row.val   = val;
		row.item  = '0;
		row.reps  = 0;
		row.typed = 1'b0;
		row.want  = '0;
		plan.push_back(row);
	endfunction

	function automatic void plan_item(input cfdp_pkg::mode_t mode,
		input logic [cfdp_pkg::COL_W-1:0] col,
		input logic [cfdp_pkg::Y_W-1:0] ar, input logic [cfdp_pkg::Y_W-1:0] ai,
		input logic [cfdp_pkg::Y_W-1:0] xr, input logic [cfdp_pkg::Y_W-1:0] xi,
		input logic [cfdp_pkg::Y_W-1:0] yr, input logic [cfdp_pkg::Y_W-1:0] yi,
		input int reps);
		plan_row_t row;
		row.kind      = ROW_ITEM;
		row.idx       = cfdp_pkg::REG_CONJ_A;
		row.val       = '0;
		row.item      = '0;
		row.item.mode = mode;
		row.item.col  = col;
		row.item.a_re = ar;
		row.item.a_im = ai;
		row.item.x_re = xr;
		row.item.x_im = xi;
		row.item.y_re = yr;
		row.item.y_im = yi;
		row.reps      = reps;
		row.typed     = 1'b0;
		row.want      = '0;
		plan.push_back(row);
	endfunction

	// Attach a hand-derived result to the last finish row
	function automatic void plan_want(input logic [cfdp_pkg::Y_W-1:0] wre,
		input logic [cfdp_pkg::Y_W-1:0] wim, input bit wsat);
		plan_row_t row;
		row          = plan.pop_back();
		row.typed    = 1'b1;
		row.want.col  = cfdp_pkg::idx_t'(row.item.col);
		row.want.y_re = wre;
		row.want.y_im = wim;
		row.want.sat  = wsat;
		plan.push_back(row);
	endfunction

	// Register write; the caller lowers cfg_we after the last one
	task automatic write_reg(input cfdp_pkg::reg_idx_t idx,
		input logic [cfdp_pkg::CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			cfdp_pkg::REG_CONJ_A:   coef.conj_a   = val[0];
			cfdp_pkg::REG_CONJ_X:   coef.conj_x   = val[0];
			cfdp_pkg::REG_ALPHA_RE: coef.alpha_re = val;
			cfdp_pkg::REG_ALPHA_IM: coef.alpha_im = val;
			cfdp_pkg::REG_BETA_RE:  coef.beta_re  = val;
			cfdp_pkg::REG_BETA_IM:  coef.beta_im  = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Wait for all new y values, then let in-flight accumulates settle
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_y.size() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	// Offer one transaction and predict it once accepted
	task automatic push_item(input cfdp_pkg::raw_t it, input bit typed,
		input cfdp_pkg::result_t want);
		cfdp_pkg::result_t pred;
		bit                accepted;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.mode;
		s_tdata  <= cfdp_pkg::S_TDATA_W'({it.y_im, it.y_re, it.x_im, it.x_re,
			it.a_im, it.a_re, it.col});
		accepted = 1'b0;
		while (!accepted) begin
			@(posedge clk);
			if (s_tready) begin
				accepted = 1'b1;
				if (column_update(it, pred))
					pending_y.push_back(typed ? want : pred);
			end
			@(negedge clk);
		end
	endtask

	// Output side back-pressure
	initial begin
		forever begin
			@(negedge clk);
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Output checker
	always @(posedge clk) begin
		cfdp_pkg::result_t got;
		cfdp_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.col  = m_tdata[cfdp_pkg::COL_W-1:0];
			got.y_re = m_tdata[cfdp_pkg::COL_W +: cfdp_pkg::Y_W];
			got.y_im = m_tdata[cfdp_pkg::COL_W+cfdp_pkg::Y_W +: cfdp_pkg::Y_W];
			got.sat  = m_tuser;
			if (pending_y.size() == 0) begin
				$display("%0t: unexpected y: col=%0d y=(%0d,%0d) sat=%0b", $time,
					got.col, got.y_re, got.y_im, got.sat);
				mismatches++;
			end else begin
				want = pending_y.pop_front();
				if (got !== want) begin
					$display("%0t: y mismatch: expected col=%0d y=(%0d,%0d) sat=%0b",
						$time, want.col, want.y_re, want.y_im, want.sat);
					$display("%0t:             actual   col=%0d y=(%0d,%0d) sat=%0b",
						$time, got.col, got.y_re, got.y_im, got.sat);
					mismatches++;
				end
			end
		end
	end

	// Run limit
	initial begin
		#10000000;
		$display("FAIL");
		$finish;
	end

	initial begin
		cfdp_pkg::result_t          none;
		int                         r, phase_no, col, n_acc, count;
		logic [cfdp_pkg::CFG_W-1:0] v_ca, v_cx, v_ar, v_ai, v_br, v_bi;

		none = '0;
		for (int c = 0; c < cfdp_pkg::NCOLS; c++) begin
			acc_re_q[c]   = 0;
			acc_im_q[c]   = 0;
			acc_clip_q[c] = 1'b0;
		end
		coef          = '0;
		coef.alpha_re = cfdp_pkg::Y_MAX;

		// after reset: beta is zero and nothing accumulated
		plan_item(M_FIN, 0, 0, 0, 0, 0, QMAX, QMIN, 1);
		plan_want(0, 0, 1'b0);
		plan_item(M_ACC, 0, QMAX, QMAX, QMAX, QMAX, 0, 0, 1);
		plan_item(M_ACC, 0, QMIN, QMIN, QMIN, QMIN, 0, 0, 1);
		plan_item(M_FIN, 0, 0, 0, 0, 0, QMIN, QMAX, 1);
		// both operands conjugated
		plan_cfg(cfdp_pkg::REG_CONJ_A, 1);
		plan_cfg(cfdp_pkg::REG_CONJ_X, 1);
		plan_item(M_ACC, 3, QMIN, QMIN, QMIN, QMAX, 0, 0, 1);
		plan_item(M_ACC, 3, QMAX, 0, 0, QMIN, 0, 0, 1);
		plan_item(M_FIN, 3, QMAX, QMIN, QMAX, QMIN, 16'sd77, -16'sd3, 1);
		// zero alpha: only beta*y remains
		plan_cfg(cfdp_pkg::REG_ALPHA_RE, 0);
		plan_cfg(cfdp_pkg::REG_ALPHA_IM, 0);
		plan_cfg(cfdp_pkg::REG_BETA_RE, QMAX);
		plan_item(M_ACC, 4, QMAX, QMIN, QMIN, QMIN, 0, 0, 1);
		plan_item(M_FIN, 4, 0, 0, 0, 0, 16'sd1234, -16'sd555, 1);
		// finish with nothing accumulated, beta*y clips the imaginary part
		plan_cfg(cfdp_pkg::REG_BETA_RE, QMIN);
		plan_cfg(cfdp_pkg::REG_BETA_IM, QMIN);
		plan_item(M_FIN, 5, 0, 0, 0, 0, QMIN, QMIN, 1);
		plan_want(0, QMAX, 1'b1);
		// zero beta with most negative alpha
		plan_cfg(cfdp_pkg::REG_ALPHA_RE, QMIN);
		plan_cfg(cfdp_pkg::REG_ALPHA_IM, QMIN);
		plan_cfg(cfdp_pkg::REG_BETA_RE, 0);
		plan_cfg(cfdp_pkg::REG_BETA_IM, 0);
		plan_cfg(cfdp_pkg::REG_CONJ_A, 0);
		plan_cfg(cfdp_pkg::REG_CONJ_X, 0);
		plan_item(M_ACC, 6, QMAX, QMIN, QMIN, QMAX, 0, 0, 1);
		plan_item(M_FIN, 6, 0, 0, 0, 0, QMAX, QMAX, 1);
		// long accumulation, imaginary part upward, scaled result clips
		plan_cfg(cfdp_pkg::REG_ALPHA_RE, QMAX);
		plan_item(M_ACC, 2, QMIN, QMIN, QMIN, QMIN, 0, 0, 32);
		plan_item(M_FIN, 2, 0, 0, 0, 0, QMAX, QMIN, 1);
		// long accumulation, real part downward
		plan_item(M_ACC, 7, QMIN, QMIN, QMAX, QMIN, 0, 0, 32);
		plan_item(M_FIN, 7, 0, 0, 0, 0, QMIN, QMAX, 1);

		// reset
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				drain_results();
				write_reg(plan[i].idx, plan[i].val);
				cfg_we <= 1'b0;
			end else begin
				for (r = 0; r < plan[i].reps; r++)
					push_item(plan[i].item, plan[i].typed, plan[i].want);
			end
		end

		// random column runs under changing coefficients and idle mixes
		for (phase_no = 0; phase_no < 8; phase_no++) begin
			case (phase_no % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 75;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 75;
				end
				default: begin
					send_idle_pct  = 7;
					recv_stall_pct = 7;
				end
			endcase
			case (phase_no)
				0: begin
					v_ca = 1;
					v_cx = 1;
					v_ar = QMIN;
					v_ai = QMIN;
					v_br = QMAX;
					v_bi = QMAX;
				end
				1: begin
					v_ca = 0;
					v_cx = 0;
					v_ar = QMAX;
					v_ai = QMAX;
					v_br = QMIN;
					v_bi = QMIN;
				end
				default: begin
					v_ca = cfdp_pkg::CFG_W'($urandom_range(1));
					v_cx = cfdp_pkg::CFG_W'($urandom_range(1));
					v_ar = rand_q15();
					v_ai = rand_q15();
					v_br = rand_q15();
					v_bi = rand_q15();
				end
			endcase
			drain_results();
			write_reg(cfdp_pkg::REG_CONJ_A, v_ca);
			write_reg(cfdp_pkg::REG_CONJ_X, v_cx);
			write_reg(cfdp_pkg::REG_ALPHA_RE, v_ar);
			write_reg(cfdp_pkg::REG_ALPHA_IM, v_ai);
			write_reg(cfdp_pkg::REG_BETA_RE, v_br);
			write_reg(cfdp_pkg::REG_BETA_IM, v_bi);
			cfg_we <= 1'b0;

			count = 0;
			while (count < 105) begin
				if ($urandom_range(99) < 15) begin
					// noise: any mode, any column
					push_item(rand_item(cfdp_pkg::mode_t'(1'($urandom_range(1))),
						cfdp_pkg::COL_W'($urandom_range(cfdp_pkg::NCOLS - 1))),
						1'b0, none);
					count++;
				end else begin
					// a column run: some accumulates then its finish
					col   = $urandom_range(cfdp_pkg::NCOLS - 1);
					n_acc = $urandom_range(6);
					repeat (n_acc)
						push_item(rand_item(M_ACC, cfdp_pkg::COL_W'(col)), 1'b0, none);
					push_item(rand_item(M_FIN, cfdp_pkg::COL_W'(col)), 1'b0, none);
					count += n_acc + 1;
				end
			end
		end

		drain_results();
		if (mismatches == 0 && pending_y.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

### complex_fused_dot_product_top.f
design/cfdp_pkg.sv
design/cfdp_front.sv
design/cfdp_fifo.sv
design/cfdp_back.sv
design/complex_fused_dot_product_top.sv
tb/tb_top.sv
